// ----- src/base40_name_codec_assert.svh -----
// Assertion macros for the base-40 name codec.
// No dependencies; included by the RTL files that carry assertions.
`ifndef BASE40_NAME_CODEC_ASSERT_SVH
`define BASE40_NAME_CODEC_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define B40NC_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("codec assertion failed");

// Antecedent implies consequent in the same cycle.
`define B40NC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("codec assertion failed");

// Antecedent implies consequent in the next cycle.
`define B40NC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("codec assertion failed");

`endif

// ----- src/b40nc_pkg.sv -----
// Types, constants and character tables for the base-40 name codec.
// No dependencies; imported by base40_name_codec and its testbench.
`default_nettype none

package b40nc_pkg;

   localparam int NAME_CHARS = 12;
   localparam int WORD_BITS  = 64;
   localparam int CNT_BITS   = 4;
   localparam int BIT_CNT_W  = $clog2(WORD_BITS);
   localparam int DIGIT_W    = 6;

   localparam logic [DIGIT_W-1:0] RADIX      = 6'd40;
   localparam logic [DIGIT_W-1:0] HALF_RADIX = 6'd20;

   localparam logic [DIGIT_W-1:0] CODE_SPACE  = 6'd0;
   localparam logic [DIGIT_W-1:0] CODE_DOLLAR = 6'd27;
   localparam logic [DIGIT_W-1:0] CODE_DOT    = 6'd28;
   localparam logic [DIGIT_W-1:0] CODE_OTHER  = 6'd29;

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef digit_type [NAME_CHARS-1:0] digits_type;

   typedef enum logic {
      ACT_ENCODE = 1'b0,
      ACT_DECODE = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      KIND_WORD  = 2'd0,
      KIND_CHAR  = 2'd1,
      KIND_EMPTY = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV_ENC,
      ST_EMIT_ENC,
      ST_CONV_DEC,
      ST_EMIT_DEC
   } state_type;

   typedef struct packed {
      action_type          action;
      logic [7:0]          char_in;
      logic                name_end;
      logic [WORD_BITS-1:0] word_in;
      logic [CNT_BITS-1:0] max_chars;
   } req_type;

   typedef struct packed {
      kind_type            kind;
      logic [WORD_BITS-1:0] word_out;
      logic [7:0]          char_out;
      logic [CNT_BITS-1:0] char_count;
      logic                last;
   } rsp_type;

   // Map a character byte to its base-40 digit; letters fold case.
   function automatic digit_type code_of(input logic [7:0] ch);
      digit_type code;
      case (ch) inside
         [8'h41:8'h5A]: code = DIGIT_W'(ch - 8'h40);
         [8'h61:8'h7A]: code = DIGIT_W'(ch - 8'h60);
         [8'h30:8'h39]: code = DIGIT_W'(ch - 8'h12);
         8'h20:         code = CODE_SPACE;
         8'h24:         code = CODE_DOLLAR;
         8'h2E:         code = CODE_DOT;
         default:       code = CODE_OTHER;
      endcase
      return code;
   endfunction

   // Map a base-40 digit back to an upper-case ASCII byte.
   function automatic logic [7:0] char_of(input digit_type code);
      logic [7:0] ch;
      case (code) inside
         CODE_SPACE:    ch = 8'h20;
         [6'd1:6'd26]:  ch = 8'h40 + {2'b00, code};
         [6'd30:6'd39]: ch = 8'h12 + {2'b00, code};
         CODE_DOLLAR:   ch = 8'h24;
         CODE_DOT:      ch = 8'h2E;
         default:       ch = 8'h3F;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

// ----- src/base40_name_codec.sv -----
// An encode request without end of name gives no result; its character joins the pending name while there is room.
// An ending encode request runs a bit-serial radix conversion, then gives the word.
// A decode request runs the conversion, then gives one character per cycle (up to 12) while the result
// side does not stall, or one empty result; one request is in work at a time.
// Synchronous active-high reset clears the pending name, the state and the result valid flag.
`default_nettype none
`include "base40_name_codec_assert.svh"

module base40_name_codec (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  b40nc_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output b40nc_pkg::rsp_type   rsp_data
);
   import b40nc_pkg::*;

   state_type                state_ff, state_in;
   digits_type               enc_ff, enc_in;
   logic [CNT_BITS-1:0]      taken_ff, taken_in;
   digits_type               work_ff, work_in;
   logic [WORD_BITS-1:0]     shift_ff, shift_in;
   logic [BIT_CNT_W-1:0]     bit_cnt_ff, bit_cnt_in;
   logic [CNT_BITS-1:0]      limit_ff, limit_in;
   logic [CNT_BITS-1:0]      dec_cnt_ff, dec_cnt_in;
   logic [CNT_BITS-1:0]      word_cnt_ff, word_cnt_in;
   rsp_type                  rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // shared helper terms
   logic                     out_free;
   logic                     conv_done;
   logic                     req_take;
   logic                     enc_end;
   logic                     work_zero;
   logic                     dec_empty;
   logic                     dec_last;
   logic [CNT_BITS-1:0]      dec_next_cnt;
   digits_type               work_up;
   digits_type               enc_next;
   logic [CNT_BITS-1:0]      taken_next;
   logic [NAME_CHARS-1:0]    carry;
   logic [NAME_CHARS-1:0]    carry_below;
   logic [NAME_CHARS-1:0]    lsb_above;
   logic [DIGIT_W:0]         dbl [NAME_CHARS];

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      conv_done = (bit_cnt_ff == BIT_CNT_W'(WORD_BITS - 1));
      req_take  = req_valid && (state_ff == ST_IDLE);
      work_zero = (work_ff == '0);
      for (int i = 0; i < NAME_CHARS; i++) begin
         work_up[i]     = (i == 0) ? CODE_SPACE : work_ff[(i + NAME_CHARS - 1) % NAME_CHARS];
         carry[i]       = (work_ff[i] >= HALF_RADIX);
         lsb_above[i]   = (i == NAME_CHARS - 1) ? 1'b0 :
                          work_ff[(i + 1) % NAME_CHARS][0];
      end
      for (int i = 0; i < NAME_CHARS; i++) begin
         carry_below[i] = (i == 0) ? shift_ff[WORD_BITS-1] :
                          carry[(i + NAME_CHARS - 1) % NAME_CHARS];
         dbl[i]         = {work_ff[i], carry_below[i]};
      end
      dec_next_cnt = dec_cnt_ff + 1'b1;
      dec_empty    = (dec_cnt_ff == '0) && (work_zero || limit_ff == '0);
      dec_last     = (work_up == '0) || (dec_next_cnt == limit_ff);

      // place the new character so the first one lands in the top digit
      enc_next   = enc_ff;
      taken_next = taken_ff;
      if (req_data.char_in != 8'h00 && taken_ff < CNT_BITS'(NAME_CHARS)) begin
         for (int i = 0; i < NAME_CHARS; i++) begin
            if (CNT_BITS'(i) == CNT_BITS'(NAME_CHARS - 1) - taken_ff) begin
               enc_next[i] = code_of(req_data.char_in);
            end
         end
         taken_next = taken_ff + 1'b1;
      end
      enc_end = (req_data.char_in == 8'h00) || req_data.name_end;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.action == ACT_DECODE) begin
                  state_in = ST_CONV_DEC;
               end else if (enc_end) begin
                  state_in = ST_CONV_ENC;
               end
            end
         end
         ST_CONV_ENC: begin
            if (conv_done) state_in = ST_EMIT_ENC;
         end
         ST_EMIT_ENC: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_CONV_DEC: begin
            if (conv_done) state_in = ST_EMIT_DEC;
         end
         ST_EMIT_DEC: begin
            if (out_free && (dec_empty || dec_last)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_stall    = (state_ff != ST_IDLE);
      enc_in       = enc_ff;
      taken_in     = taken_ff;
      work_in      = work_ff;
      shift_in     = shift_ff;
      bit_cnt_in   = bit_cnt_ff;
      limit_in     = limit_ff;
      dec_cnt_in   = dec_cnt_ff;
      word_cnt_in  = word_cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               bit_cnt_in = '0;
               if (req_data.action == ACT_ENCODE) begin
                  if (enc_end) begin
                     // hand the finished name to the converter and start a fresh one
                     work_in     = enc_next;
                     word_cnt_in = taken_next;
                     enc_in      = '0;
                     taken_in    = '0;
                  end else begin
                     enc_in   = enc_next;
                     taken_in = taken_next;
                  end
               end else begin
                  shift_in   = req_data.word_in;
                  work_in    = '0;
                  dec_cnt_in = '0;
                  limit_in   = (req_data.max_chars > CNT_BITS'(NAME_CHARS)) ?
                               CNT_BITS'(NAME_CHARS) : req_data.max_chars;
               end
            end
         end
         ST_CONV_ENC: begin
            // halve the base-40 value, shifting its parity out as the next binary bit
            shift_in   = {work_ff[0][0], shift_ff[WORD_BITS-1:1]};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            for (int i = 0; i < NAME_CHARS; i++) begin
               work_in[i] = {1'b0, work_ff[i][DIGIT_W-1:1]} +
                            (lsb_above[i] ? HALF_RADIX : CODE_SPACE);
            end
         end
         ST_CONV_DEC: begin
            // double the base-40 value and add the next word bit; top carry drops
            shift_in   = {shift_ff[WORD_BITS-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            for (int i = 0; i < NAME_CHARS; i++) begin
               work_in[i] = carry[i] ? DIGIT_W'(dbl[i] - {1'b0, RADIX}) : dbl[i][DIGIT_W-1:0];
            end
         end
         ST_EMIT_ENC: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.kind        = KIND_WORD;
               rsp_in.word_out    = shift_ff;
               rsp_in.char_out    = 8'h00;
               rsp_in.char_count  = word_cnt_ff;
               rsp_in.last        = 1'b1;
            end
         end
         ST_EMIT_DEC: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.word_out = '0;
               if (dec_empty) begin
                  rsp_in.kind       = KIND_EMPTY;
                  rsp_in.char_out   = 8'h00;
                  rsp_in.char_count = '0;
                  rsp_in.last       = 1'b1;
               end else begin
                  rsp_in.kind       = KIND_CHAR;
                  rsp_in.char_out   = char_of(work_ff[NAME_CHARS-1]);
                  rsp_in.char_count = dec_next_cnt;
                  rsp_in.last       = dec_last;
                  dec_cnt_in        = dec_next_cnt;
                  work_in           = work_up;
               end
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enc_ff       <= '0;
         taken_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enc_ff       <= enc_in;
         taken_ff     <= taken_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      shift_ff    <= shift_in;
      bit_cnt_ff  <= bit_cnt_in;
      limit_ff    <= limit_in;
      dec_cnt_ff  <= dec_cnt_in;
      word_cnt_ff <= word_cnt_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `B40NC_ASSERT_IMPLIES(a_enc_cleared, clock, reset,
      state_ff == ST_CONV_ENC, taken_ff == '0 && enc_ff == '0)
   `B40NC_ASSERT_IMPLIES(a_dec_within_limit, clock, reset,
      state_ff == ST_EMIT_DEC, dec_cnt_ff < limit_ff || dec_cnt_ff == '0)
   `B40NC_ASSERT_NEXT(a_conv_dec_len, clock, reset,
      state_ff == ST_CONV_DEC && conv_done, state_ff == ST_EMIT_DEC)
   `B40NC_ASSERT_IMPLIES(a_empty_is_last, clock, reset,
      rsp_valid_ff && rsp_ff.kind == KIND_EMPTY, rsp_ff.last && rsp_ff.char_count == '0)

endmodule

`default_nettype wire

// ----- test/tb_base40_name_codec.sv -----
// Self-checking testbench for base40_name_codec: encodes names and decodes words, predicting
// every result in step with each accepted request and checking them field by field.
// Depends on b40nc_pkg and the codec RTL only.
`default_nettype none

module tb_base40_name_codec;
   import b40nc_pkg::*;

   // Weight of the top base-40 digit, and the span of a full twelve-digit word.
   localparam logic [63:0] TOP_WEIGHT  = 64'd419430400000000000;
   localparam logic [63:0] WORD_SPAN   = 64'd16777216000000000000;
   localparam int          CYCLE_LIMIT = 300000;
   localparam int          SETTLE      = 100;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type     pending_results[$];
   logic [63:0] name_acc = '0;
   logic [3:0]  name_len = '0;
   int          mismatches = 0;
   int          requests_sent = 0;
   int          cycle_count = 0;
   bit          steady = 1'b0;

   base40_name_codec dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [5:0] digit_for(input logic [7:0] ch);
      if (ch >= "A" && ch <= "Z") return 6'(ch - "A" + 8'd1);
      if (ch >= "a" && ch <= "z") return 6'(ch - "a" + 8'd1);
      if (ch >= "0" && ch <= "9") return 6'(ch - "0" + 8'd30);
      if (ch == " ") return 6'd0;
      if (ch == "$") return 6'd27;
      if (ch == ".") return 6'd28;
      return 6'd29;
   endfunction

   function automatic logic [7:0] byte_for_digit(input logic [5:0] d);
      if (d == 6'd0) return " ";
      if (d <= 6'd26) return 8'("A" + d - 6'd1);
      if (d >= 6'd30) return 8'("0" + d - 6'd30);
      if (d == 6'd27) return "$";
      if (d == 6'd28) return ".";
      return "?";
   endfunction

   // Work out the results of one accepted request and queue them.
   task automatic predict_request(input req_type r);
      rsp_type     exp;
      logic [63:0] rest;
      logic [63:0] padded;
      logic        ends;
      int          limit;
      int          n;
      int          i;
      exp = '0;
      if (r.action == ACT_ENCODE) begin
         ends = r.name_end;
         if (r.char_in == 8'h00) begin
            ends = 1'b1;
         end else if (name_len < NAME_CHARS) begin
            name_acc = name_acc * 64'd40 + 64'(digit_for(r.char_in));
            name_len = name_len + 4'd1;
         end
         if (ends) begin
            padded = name_acc;
            for (i = name_len; i < NAME_CHARS; i++) padded = padded * 64'd40;
            exp.kind       = KIND_WORD;
            exp.word_out   = padded;
            exp.char_count = name_len;
            exp.last       = 1'b1;
            pending_results.push_back(exp);
            name_acc = '0;
            name_len = '0;
         end
      end else begin
         limit = (r.max_chars > NAME_CHARS) ? NAME_CHARS : int'(r.max_chars);
         rest  = r.word_in % WORD_SPAN;
         n     = 0;
         while (rest != 64'd0 && n < limit) begin
            exp            = '0;
            exp.kind       = KIND_CHAR;
            exp.char_out   = byte_for_digit(6'(rest / TOP_WEIGHT));
            rest           = (rest % TOP_WEIGHT) * 64'd40;
            n++;
            exp.char_count = 4'(n);
            exp.last       = (rest == 64'd0) || (n == limit);
            pending_results.push_back(exp);
         end
         if (n == 0) begin
            exp      = '0;
            exp.kind = KIND_EMPTY;
            exp.last = 1'b1;
            pending_results.push_back(exp);
         end
      end
   endtask

   task automatic report_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type exp;
      if (pending_results.size() == 0) begin
         $error("unexpected result: kind %0d word %0d char %0d", got.kind, got.word_out,
                got.char_out);
         mismatches++;
      end else begin
         exp = pending_results.pop_front();
         report_field("kind", 64'(exp.kind), 64'(got.kind));
         report_field("word_out", exp.word_out, got.word_out);
         report_field("char_out", 64'(exp.char_out), 64'(got.char_out));
         report_field("char_count", 64'(exp.char_count), 64'(got.char_count));
         report_field("last", 64'(exp.last), 64'(got.last));
      end
   endtask

   // Sample results and stall the result side at random outside the steady stream.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) check_result(rsp_data);
         rsp_stall <= !steady && ($urandom_range(99) < 14);
      end
   end

   // Hold the request until accepted, then idle now and again outside the steady stream.
   task automatic send_request(input req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_request(r);
      requests_sent++;
      if (!steady && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   function automatic req_type char_request(input logic [7:0] ch, input logic end_flag);
      req_type r;
      r.action    = ACT_ENCODE;
      r.char_in   = ch;
      r.name_end  = end_flag;
      r.word_in   = {$urandom, $urandom};
      r.max_chars = 4'($urandom_range(15));
      return r;
   endfunction

   function automatic req_type word_request(input logic [63:0] w, input logic [3:0] lim);
      req_type r;
      r.action    = ACT_DECODE;
      r.char_in   = 8'($urandom_range(255));
      r.name_end  = 1'($urandom_range(1));
      r.word_in   = w;
      r.max_chars = lim;
      return r;
   endfunction

   function automatic logic [7:0] random_char();
      case ($urandom_range(5))
         0: return 8'("A" + $urandom_range(25));
         1: return 8'("a" + $urandom_range(25));
         2: return 8'("0" + $urandom_range(9));
         3: begin
            case ($urandom_range(2))
               0: return " ";
               1: return "$";
               default: return ".";
            endcase
         end
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   function automatic logic [63:0] random_word();
      logic [63:0] w;
      int          n;
      int          i;
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            // well-formed word: a few leading digits, zero below
            w = '0;
            n = $urandom_range(12);
            for (i = 0; i < NAME_CHARS; i++)
               w = w * 64'd40 + ((i < n) ? 64'($urandom_range(39)) : 64'd0);
         end
         4, 5, 6: w = {$urandom, $urandom};
         7:       w = 64'($urandom_range(63999));
         8:       w = ~64'($urandom_range(1000));
         default: w = 64'($urandom_range(39)) * TOP_WEIGHT + 64'($urandom_range(1));
      endcase
      return w;
   endfunction

   function automatic logic [3:0] random_limit();
      if ($urandom_range(3) == 0) return 4'($urandom_range(11));
      return 4'($urandom_range(12, 15));
   endfunction

   // Thirteen characters of every class; the last is dropped but still ends the name.
   task automatic test_overlong_name();
      logic [7:0] name_bytes [13] = '{"z", "A", "0", "9", "$", ".", " ", 8'h80, 8'hFF,
                                      8'h01, "m", "Q", "7"};
      int i;
      for (i = 0; i < 13; i++) send_request(char_request(name_bytes[i], i == 12));
   endtask

   task automatic test_nul_terminator();
      send_request(char_request("K", 1'b0));
      send_request(char_request(8'h00, 1'b0));
      send_request(char_request(8'h00, 1'b1));
   endtask

   task automatic test_decode_edges();
      send_request(word_request(64'd0, 4'd12));
      send_request(word_request('1, 4'd15));
      send_request(word_request(64'd29 * TOP_WEIGHT, 4'd5));
      send_request(word_request('1, 4'd0));
      send_request(word_request(WORD_SPAN - 64'd1, 4'd13));
      send_request(word_request(64'd39 * TOP_WEIGHT + 64'd1, 4'd12));
      send_request(word_request(WORD_SPAN, 4'd12));
      // decode in the middle of a name must leave the name intact
      send_request(char_request("B", 1'b0));
      send_request(word_request({$urandom, $urandom}, 4'd3));
      send_request(char_request("c", 1'b1));
   endtask

   task automatic send_random_name();
      int len;
      int i;
      bit nul_end;
      len     = ($urandom_range(9) == 0) ? $urandom_range(13, 15) : $urandom_range(1, 12);
      nul_end = ($urandom_range(3) == 0);
      for (i = 0; i < len; i++)
         send_request(char_request(random_char(), !nul_end && i == len - 1));
      if (nul_end) send_request(char_request(8'h00, 1'($urandom_range(1))));
   endtask

   task automatic test_random_traffic(input int count);
      int target;
      int pick;
      target = requests_sent + count;
      while (requests_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 55) send_random_name();
         else if (pick < 92) send_request(word_request(random_word(), random_limit()));
         else send_request(char_request(8'($urandom_range(255)), 1'($urandom_range(1))));
      end
   endtask

   // Hold off the sender until every result is in.
   task automatic test_drain_pause();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic test_steady_stream(input int count);
      steady = 1'b1;
      test_random_traffic(count);
      steady = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_overlong_name();
      test_nul_terminator();
      test_decode_edges();
      test_random_traffic(75);
      test_drain_pause();
      test_steady_stream(60);
      test_random_traffic(70);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
